/* design/idbaf_pkg.sv */
// package for the input debounce bank with autofire
// shared types, register codes and reset values; no dependencies
`default_nettype none

package idbaf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTOFIRE_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTOFIRE_BUTTON = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS    = 3'd5;

    // reset values of the registers
    localparam logic [6:0]  RST_DEBOUNCE_LIMIT = 7'd5;
    localparam logic [7:0]  RST_BURST_LENGTH   = 8'd3;
    localparam logic [7:0]  RST_PRESS_TICKS    = 8'd9;
    localparam logic [15:0] RST_PERIOD_TICKS   = 16'd54;

    // count ceiling of the integrating counter
    localparam logic [6:0] COUNT_MAX = 7'h7f;
    // burst counter saturation
    localparam logic [7:0] PULSES_MAX = 8'hff;

    // one entry of the counter memory
    typedef struct packed {
        logic       pressed;
        logic [6:0] count;
    } t_counter;

    // autofire settings handed to the autofire unit
    typedef struct packed {
        logic        enable;
        logic [4:0]  button;
        logic [7:0]  burst_length;
        logic [7:0]  press_ticks;
        logic [15:0] period_ticks;
    } t_af_cfg;

endpackage

`default_nettype wire

/* design/idbaf_ctr_ram.sv */
// counter memory: one entry per button, registered read, one write port
// valid bits make never-written entries read as zero; uses idbaf_pkg
`default_nettype none

module idbaf_ctr_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_rd_en,
    input  wire [ADDR_W-1:0]         i_rd_addr,
    output idbaf_pkg::t_counter      o_rd_data,
    input  wire                      i_wr_en,
    input  wire [ADDR_W-1:0]         i_wr_addr,
    input  idbaf_pkg::t_counter      i_wr_data
);

    idbaf_pkg::t_counter r_mem [DEPTH];
    logic [DEPTH-1:0]    r_valid;
    idbaf_pkg::t_counter r_q;
    logic                r_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_q_valid ? r_q : '0;

endmodule

`default_nettype wire

/* design/idbaf_autofire.sv */
// autofire unit: press detect with lockout, burst counter and pulse generator
// replaces the raw level of the chosen button; uses idbaf_pkg
`default_nettype none

module idbaf_autofire (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  idbaf_pkg::t_af_cfg  i_cfg,
    input  wire                 i_en,
    input  wire [7:0]           i_idx,
    input  wire                 i_level,
    output logic                o_level
);

    logic [15:0] r_phase;
    logic [7:0]  r_pulses;
    logic [7:0]  r_lockout;
    logic [15:0] n_phase;
    logic [7:0]  n_pulses;
    logic [7:0]  n_lockout;
    logic        w_hit;
    logic [8:0]  w_sum;
    logic        w_pulse;

    assign w_hit = i_en && i_cfg.enable && (i_idx == {3'b000, i_cfg.button});
    assign w_sum = {1'b0, r_pulses} + {1'b0, i_cfg.burst_length};

    always_comb begin
        n_phase   = r_phase;
        n_pulses  = r_pulses;
        n_lockout = r_lockout;
        w_pulse   = 1'b0;
        // press detector with lockout
        if (r_lockout == 8'd0 && i_level) begin
            n_lockout = i_cfg.press_ticks;
            n_pulses  = w_sum[8] ? idbaf_pkg::PULSES_MAX : w_sum[7:0];
        end else if (r_lockout > 8'd1) begin
            n_lockout = r_lockout - 8'd1;
        end else if (r_lockout == 8'd1 && !i_level) begin
            n_lockout = 8'd0;
        end
        // pulse train
        if (n_pulses != 8'd0) begin
            w_pulse = r_phase < {8'd0, i_cfg.press_ticks};
            if (r_phase >= i_cfg.period_ticks) begin
                n_phase  = 16'd0;
                n_pulses = n_pulses - 8'd1;
            end else begin
                n_phase = r_phase + 16'd1;
            end
        end
    end

    assign o_level = w_hit ? w_pulse : i_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_pulses  <= '0;
            r_lockout <= '0;
        end else if (w_hit) begin
            r_phase   <= n_phase;
            r_pulses  <= n_pulses;
            r_lockout <= n_lockout;
        end
    end

endmodule

`default_nettype wire

/* design/input_debounce_bank_autofire.sv */
// top level of the input debounce bank with autofire
// depends on idbaf_pkg, idbaf_ctr_ram and idbaf_autofire
`default_nettype none

// Debounces scan samples for a bank of buttons with 7-bit integrating counters
// kept in one memory, one entry per button (pressed bit and count). One item
// is taken every clock cycle unless back-pressure on the results holds it; each
// result passes the registered memory read, the update stage and the output
// register. A sample for the autofire button first passes the autofire unit,
// whose pulse train replaces the raw level. Back-to-back samples for the same
// button are served by forwarding the write-back value into the next item.
// Memory entries start cleared through per-entry valid bits, so there is no
// clearing pass after reset. The user writes configuration only while idle;
// the block does not enforce it.
module input_debounce_bank_autofire #(
    parameter int NUM_BUTTONS = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write port
    input  wire                                  i_cfg_we,
    input  wire [idbaf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [idbaf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input items
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire [15:0]                           s_axis_tdata,  // button_index[7:0], raw_level[8]
    // result items
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [15:0]                          m_axis_tdata   // button_out[7:0], pressed[8], changed[9]
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // configuration registers
    logic [6:0]  r_debounce_limit;
    logic        r_af_enable;
    logic [4:0]  r_af_button;
    logic [7:0]  r_burst_length;
    logic [7:0]  r_press_ticks;
    logic [15:0] r_period_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit <= idbaf_pkg::RST_DEBOUNCE_LIMIT;
            r_af_enable      <= 1'b0;
            r_af_button      <= 5'd0;
            r_burst_length   <= idbaf_pkg::RST_BURST_LENGTH;
            r_press_ticks    <= idbaf_pkg::RST_PRESS_TICKS;
            r_period_ticks   <= idbaf_pkg::RST_PERIOD_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                idbaf_pkg::REG_DEBOUNCE_LIMIT:  r_debounce_limit <= i_cfg_data[6:0];
                idbaf_pkg::REG_AUTOFIRE_ENABLE: r_af_enable      <= i_cfg_data[0];
                idbaf_pkg::REG_AUTOFIRE_BUTTON: r_af_button      <= i_cfg_data[4:0];
                idbaf_pkg::REG_BURST_LENGTH:    r_burst_length   <= i_cfg_data[7:0];
                idbaf_pkg::REG_PRESS_TICKS:     r_press_ticks    <= i_cfg_data[7:0];
                idbaf_pkg::REG_PERIOD_TICKS:    r_period_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    idbaf_pkg::t_af_cfg w_af_cfg;
    assign w_af_cfg = '{enable:       r_af_enable,
                        button:       r_af_button,
                        burst_length: r_burst_length,
                        press_ticks:  r_press_ticks,
                        period_ticks: r_period_ticks};

    // input item fields
    logic [7:0]       w_in_idx;
    logic             w_in_level;
    logic             w_in_range;
    logic [IDX_W-1:0] w_in_addr;
    logic             w_accept;
    logic             w_af_level;

    assign w_in_idx   = s_axis_tdata[7:0];
    assign w_in_level = s_axis_tdata[8];
    assign w_in_range = {1'b0, w_in_idx} < 9'(NUM_BUTTONS);
    assign w_in_addr  = w_in_idx[IDX_W-1:0];

    // update stage and output register
    logic                r_s1_vld;
    logic [7:0]          r_s1_idx;
    logic                r_s1_range;
    logic                r_s1_level;
    logic                r_s1_fwd;
    idbaf_pkg::t_counter r_s1_fwd_data;
    logic                r_out_vld;
    logic [15:0]         r_out_data;
    logic                w_s1_adv;
    logic                w_wr_en;
    idbaf_pkg::t_counter w_rd_data;
    idbaf_pkg::t_counter w_cur;
    idbaf_pkg::t_counter n_ctr;
    logic                n_changed;

    // stage one moves on when the output register is free or being emptied
    assign w_s1_adv      = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || w_s1_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_wr_en       = w_s1_adv && r_s1_range;

    // autofire replaces the level of the chosen button
    idbaf_autofire u_autofire (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_af_cfg),
        .i_en    (w_accept && w_in_range),
        .i_idx   (w_in_idx),
        .i_level (w_in_level),
        .o_level (w_af_level)
    );

    idbaf_ctr_ram #(
        .DEPTH  (NUM_BUTTONS),
        .ADDR_W (IDX_W)
    ) u_ctr_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_in_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_idx[IDX_W-1:0]),
        .i_wr_data (n_ctr)
    );

    // the write-back of the item ahead lands on the same edge as this read
    assign w_cur = r_s1_fwd ? r_s1_fwd_data : w_rd_data;

    // integrating counter update
    always_comb begin
        n_ctr     = w_cur;
        n_changed = 1'b0;
        if (r_s1_level) begin
            if (w_cur.count <= r_debounce_limit) begin
                if (w_cur.count == r_debounce_limit && !w_cur.pressed) begin
                    n_changed     = 1'b1;
                    n_ctr.pressed = 1'b1;
                end
                if (w_cur.count != idbaf_pkg::COUNT_MAX) begin
                    n_ctr.count = w_cur.count + 7'd1;
                end
            end
        end else begin
            if (w_cur.count != 7'd0) begin
                if (w_cur.count == 7'd1 && w_cur.pressed) begin
                    n_changed     = 1'b1;
                    n_ctr.pressed = 1'b0;
                end
                n_ctr.count = w_cur.count - 7'd1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_idx      <= w_in_idx;
            r_s1_range    <= w_in_range;
            r_s1_level    <= w_af_level;
            r_s1_fwd      <= w_wr_en && (r_s1_idx == w_in_idx);
            r_s1_fwd_data <= n_ctr;
        end
        if (w_s1_adv) begin
            r_out_data <= {6'd0,
                           r_s1_range & n_changed,
                           r_s1_range & n_ctr.pressed,
                           r_s1_idx};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
